// File: sv/lcrta_pkg.sv
// Shared types and constants for the load cell readout with tare and alert.
// No dependencies; imported by lcrta_div and load_cell_readout_tare_alert_unit.
`default_nettype none

package lcrta_pkg;

  localparam int FORCE_W = 24;
  localparam int GAIN_W  = 16;
  localparam int CFG_W   = 24;

  localparam logic [FORCE_W-1:0] FORCE_MAX   = 24'hFFFFFF;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd430;
  localparam logic [FORCE_W-1:0] LIMIT_RESET = 24'd20;

  // Configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_GAIN  = 1'b0;
  localparam cfg_idx_t REG_LIMIT = 1'b1;

  // Frame kinds
  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_TARE    = 1'b1;

  // Divider handshake back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: sv/lcrta_div.sv
// Restoring divider, one quotient bit per cycle, for the force scaling.
// Depends on lcrta_pkg (divisor width, status struct).
`default_nettype none

module lcrta_div
  import lcrta_pkg::*;
#(
  parameter int DW = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DW-1:0]     dividend,
  input  wire logic [GAIN_W-1:0] divisor,
  output div_stat_t              stat,
  output logic      [DW-1:0]     quotient
);

  localparam int CNT_W = $clog2(DW);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [GAIN_W-1:0] dvs;
  logic [GAIN_W-1:0] rem;
  logic [DW-1:0]     qreg;

  logic [GAIN_W:0]   trial;
  logic              fits;
  logic [GAIN_W:0]   diff;

  // trial remainder: bring down next dividend bit
  assign trial = {rem, qreg[DW-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvs  <= (divisor == '0) ? GAIN_W'(1) : divisor;
      rem  <= '0;
      qreg <= dividend;
    end else if (busy) begin
      rem  <= fits ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
      qreg <= {qreg[DW-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = qreg;

endmodule

`default_nettype wire

// File: sv/load_cell_readout_tare_alert_unit.sv
// Top level: serial frame capture, tare, force scaling and one-shot alert.
// Depends on lcrta_pkg and lcrta_div.
//
// Use:
//  - Input channel (in_valid/in_stall): one beat carries one converter data
//    bit (data_bit, MSB first) and req_type. The req_type of the beat that
//    completes a frame decides tare (1) or measure (0).
//  - Output channel (out_valid/out_stall): one beat per completed frame with
//    frame_kind, raw_value (frame with top bit inverted), force_value,
//    over_limit and alert_pulse. No beat for the other bits.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is the
//    gain divisor (0 acts as 1), index 1 the force limit. Always ready;
//    write only while idle.
// Sequence: a bit that does not end a frame is taken while idle. The
//  frame-ending bit leads to the check state; then, for a measure frame with
//  raw above tare, the restoring divider runs until its done flag, and the
//  emit state loads the output register. in_stall is high once that bit is
//  taken until the result is loaded.
//  A result waiting under out_stall does not block the next frame's bits;
//  only a further frame end waits for the output register to free.
// Reset: clears the frame, bit count, tare, force and alert latch, and
//  loads gain 430 and limit 20. No output beat is pending after reset.
`default_nettype none

module load_cell_readout_tare_alert_unit
  import lcrta_pkg::*;
#(
  parameter int FRAME_BITS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input bits
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               req_type,
  input  wire logic               data_bit,
  // results
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    frame_kind,
  output logic [FORCE_W-1:0]      raw_value,
  output logic [FORCE_W-1:0]      force_value,
  output logic                    over_limit,
  output logic                    alert_pulse,
  // configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire cfg_idx_t           cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  localparam int BIT_W = $clog2(FRAME_BITS);

  // sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;  // taking bits
  localparam logic [1:0] S_CHECK = 2'd1;  // tare store or divide launch
  localparam logic [1:0] S_DIV   = 2'd2;  // divider running
  localparam logic [1:0] S_EMIT  = 2'd3;  // alert logic, load output

  logic [1:0]            state;
  logic [1:0]            state_next;

  logic [GAIN_W-1:0]     gain_divisor;
  logic [FORCE_W-1:0]    force_limit;

  logic [FRAME_BITS-1:0] shift_word;
  logic [BIT_W-1:0]      bit_index;
  logic [FRAME_BITS-1:0] tare_value;
  logic [FORCE_W-1:0]    last_force;
  logic                  alert_latched;

  logic [FRAME_BITS-1:0] raw;
  logic                  kind;

  logic                  in_take;
  logic                  frame_end;
  logic [FRAME_BITS-1:0] shift_next;

  logic                  div_start;
  div_stat_t             div_stat;
  logic [FRAME_BITS-1:0] div_q;
  logic [31:0]           q_wide;
  logic [31:0]           raw_wide;

  logic                  emit_go;
  logic                  over_now;
  logic                  pulse_now;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign frame_end = (bit_index == BIT_W'(FRAME_BITS - 1));
  assign shift_next = {shift_word[FRAME_BITS-2:0], data_bit};

  assign div_start = (state == S_CHECK) && (kind == KIND_MEASURE) && (raw > tare_value);

  assign emit_go   = (state == S_EMIT) && (!out_valid || !out_stall);
  assign over_now  = last_force > force_limit;
  assign pulse_now = (kind == KIND_MEASURE) && over_now && !alert_latched;

  assign q_wide   = 32'(div_q);
  assign raw_wide = 32'(raw);

  lcrta_div #(
    .DW (FRAME_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (raw - tare_value),
    .divisor  (gain_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take && frame_end) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = div_start ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        if (div_stat.done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      gain_divisor  <= GAIN_RESET;
      force_limit   <= LIMIT_RESET;
      shift_word    <= '0;
      bit_index     <= '0;
      tare_value    <= '0;
      last_force    <= '0;
      alert_latched <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN:  gain_divisor <= cfg_data[GAIN_W-1:0];
          REG_LIMIT: force_limit  <= cfg_data[FORCE_W-1:0];
          default: ;
        endcase
      end

      if (in_take) begin
        if (frame_end) begin
          shift_word <= '0;
          bit_index  <= '0;
        end else begin
          shift_word <= shift_next;
          bit_index  <= bit_index + 1'b1;
        end
      end

      if (state == S_CHECK && kind == KIND_TARE) tare_value <= raw;

      // saturate the quotient to the force width
      if (state == S_DIV && div_stat.done) begin
        last_force <= (q_wide > 32'(FORCE_MAX)) ? FORCE_MAX : q_wide[FORCE_W-1:0];
      end

      if (emit_go && kind == KIND_MEASURE) alert_latched <= over_now;

      if (emit_go)         out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // frame capture: top bit flipped to offset binary
  always_ff @(posedge clk) begin
    if (in_take && frame_end) begin
      raw  <= shift_next ^ {1'b1, {(FRAME_BITS-1){1'b0}}};
      kind <= req_type;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit_go) begin
      frame_kind  <= kind;
      raw_value   <= raw_wide[FORCE_W-1:0];
      force_value <= last_force;
      over_limit  <= over_now;
      alert_pulse <= pulse_now;
    end
  end

  // divider only runs under its own sequencer state
  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == S_DIV)
    else $error("divider busy outside divide state");

  // an alert beat always reports over limit on a measure frame
  a_pulse_meaning: assert property (@(posedge clk) disable iff (rst)
    out_valid && alert_pulse |-> over_limit && frame_kind == KIND_MEASURE)
    else $error("alert pulse without over-limit measure frame");

  // a delivered pulse leaves the latch set
  a_pulse_latch: assert property (@(posedge clk) disable iff (rst)
    out_valid && alert_pulse |-> alert_latched)
    else $error("alert pulse but latch clear");

  // no bit is taken while a frame end is being processed
  a_hold_bits: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |=> $stable(bit_index) || $past(state) == S_IDLE)
    else $error("bit count moved during frame processing");

endmodule

`default_nettype wire
